// ----- sv/snpl_pkg.sv -----
// Package for the subnet nearest-point linker.
// Holds the token and command types shared by the cell row and the top level, and the top level's state type.
// No dependencies.
package snpl_pkg;

  typedef struct packed {
    logic vld;
    logic any;
    logic hit;
  } snpl_tok_t;

  typedef struct packed {
    logic clear;
    logic write;
  } snpl_cmd_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQ     = 6'b000010,
    ST_SUM    = 6'b000100,
    ST_LAUNCH = 6'b001000,
    ST_WALK   = 6'b010000,
    ST_DONE   = 6'b100000
  } snpl_state_e;

endpackage

// ----- sv/subnet_nearest_point_linker_top.sv -----
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o    start_net, subnet_id, point_x, point_y
// out      output     out_valid_o / out_stall_i  from_x, from_y, to_x, to_y, table_full
// An item first forms the distances in every cell (states SQ and SUM), then, from LAUNCH,
// the search token walks the row of MAX_SUBNETS cells at one cell a cycle.
// Reset clears the anchor table and the control state; no clearing pass is needed.
// A stalled output beat waits in the output register while the next item is taken and
// searched; only the final step of that item waits for the register to free up.
module subnet_nearest_point_linker_top #(
  parameter int MAX_SUBNETS = 64,
  parameter int COORD_BITS  = 24,
  parameter int SUBNET_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         start_net_i,
  input  logic [SUBNET_BITS-1:0]       subnet_id_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] from_x_o,
  output logic signed [COORD_BITS-1:0] from_y_o,
  output logic signed [COORD_BITS-1:0] to_x_o,
  output logic signed [COORD_BITS-1:0] to_y_o,
  output logic                         table_full_o
);
  import snpl_pkg::*;

  localparam int DIST_W = 2 * COORD_BITS + 2;
  localparam int CNT_W  = $clog2(MAX_SUBNETS + 1);

  snpl_state_e            state_q, state_d;
  logic [CNT_W-1:0]       count_q;
  logic [SUBNET_BITS-1:0] q_sub_q;
  logic [COORD_BITS-1:0]  q_x_q, q_y_q;
  logic                   accept, full, need_out, out_free, done_go, store, load_out;
  logic                   out_valid_q;
  logic [COORD_BITS-1:0]  from_x_q, from_y_q, to_x_q, to_y_q;
  logic                   table_full_q;

  snpl_tok_t              tok_c   [MAX_SUBNETS+1];
  logic [DIST_W-1:0]      dist_c  [MAX_SUBNETS+1];
  logic [SUBNET_BITS-1:0] sub_c   [MAX_SUBNETS+1];
  logic [COORD_BITS-1:0]  x_c     [MAX_SUBNETS+1];
  logic [COORD_BITS-1:0]  y_c     [MAX_SUBNETS+1];

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(MAX_SUBNETS));
  assign need_out   = !tok_c[MAX_SUBNETS].hit && tok_c[MAX_SUBNETS].any;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign done_go    = (state_q == ST_DONE) && (!need_out || out_free);
  assign store      = done_go && !tok_c[MAX_SUBNETS].hit && !full;
  assign load_out   = done_go && need_out;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_SQ;
      ST_SQ:     state_d = ST_SUM;
      ST_SUM:    state_d = ST_LAUNCH;
      ST_LAUNCH: state_d = ST_WALK;
      ST_WALK:   if (tok_c[MAX_SUBNETS].vld) state_d = ST_DONE;
      ST_DONE:   if (done_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
      if (accept && start_net_i) begin
        count_q <= '0;
      end else if (store) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_sub_q <= subnet_id_i;
      q_x_q   <= point_x_i;
      q_y_q   <= point_y_i;
    end
    if (load_out) begin
      from_x_q     <= x_c[MAX_SUBNETS];
      from_y_q     <= y_c[MAX_SUBNETS];
      to_x_q       <= q_x_q;
      to_y_q       <= q_y_q;
      table_full_q <= full;
    end
  end

  assign tok_c[0].vld = (state_q == ST_LAUNCH);
  assign tok_c[0].any = 1'b0;
  assign tok_c[0].hit = 1'b0;
  assign dist_c[0]    = '0;
  assign sub_c[0]     = '0;
  assign x_c[0]       = '0;
  assign y_c[0]       = '0;

  for (genvar k = 0; k < MAX_SUBNETS; k++) begin : g_cell
    snpl_cmd_t cmd;
    assign cmd.clear = accept && start_net_i;
    assign cmd.write = store && (count_q == CNT_W'(k));

    snpl_cell #(
      .SUBNET_BITS (SUBNET_BITS),
      .COORD_BITS  (COORD_BITS),
      .DIST_W      (DIST_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .q_sub_i     (q_sub_q),
      .q_x_i       (q_x_q),
      .q_y_i       (q_y_q),
      .tok_i       (tok_c[k]),
      .best_dist_i (dist_c[k]),
      .best_sub_i  (sub_c[k]),
      .best_x_i    (x_c[k]),
      .best_y_i    (y_c[k]),
      .tok_o       (tok_c[k+1]),
      .best_dist_o (dist_c[k+1]),
      .best_sub_o  (sub_c[k+1]),
      .best_x_o    (x_c[k+1]),
      .best_y_o    (y_c[k+1])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign from_x_o     = from_x_q;
  assign from_y_o     = from_y_q;
  assign to_x_o       = to_x_q;
  assign to_y_o       = to_y_q;
  assign table_full_o = table_full_q;

endmodule

// ----- sv/snpl_cell.sv -----
// One anchor cell of the linker row: holds one anchor and its distance to the query.
// Compares the passing search token against its own anchor and hands it on.
// Depends on snpl_pkg.
module snpl_cell #(
  parameter int SUBNET_BITS = 16,
  parameter int COORD_BITS  = 24,
  parameter int DIST_W      = 2 * COORD_BITS + 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  snpl_pkg::snpl_cmd_t    cmd_i,
  input  logic [SUBNET_BITS-1:0] q_sub_i,
  input  logic [COORD_BITS-1:0]  q_x_i,
  input  logic [COORD_BITS-1:0]  q_y_i,
  input  snpl_pkg::snpl_tok_t    tok_i,
  input  logic [DIST_W-1:0]      best_dist_i,
  input  logic [SUBNET_BITS-1:0] best_sub_i,
  input  logic [COORD_BITS-1:0]  best_x_i,
  input  logic [COORD_BITS-1:0]  best_y_i,
  output snpl_pkg::snpl_tok_t    tok_o,
  output logic [DIST_W-1:0]      best_dist_o,
  output logic [SUBNET_BITS-1:0] best_sub_o,
  output logic [COORD_BITS-1:0]  best_x_o,
  output logic [COORD_BITS-1:0]  best_y_o
);
  import snpl_pkg::*;

  logic                   valid_q;
  logic [SUBNET_BITS-1:0] sub_q;
  logic [COORD_BITS-1:0]  x_q;
  logic [COORD_BITS-1:0]  y_q;
  logic [COORD_BITS:0]    dx, dy;
  logic [COORD_BITS:0]    mag_x, mag_y;
  logic [DIST_W-1:0]      sqx_d, sqy_d, sqx_q, sqy_q, dist_q;
  logic                   better, take, hit_here;
  snpl_tok_t              tok_q;
  logic [DIST_W-1:0]      best_dist_q;
  logic [SUBNET_BITS-1:0] best_sub_q;
  logic [COORD_BITS-1:0]  best_x_q, best_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.clear) begin
      valid_q <= 1'b0;
    end else if (cmd_i.write) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      sub_q <= q_sub_i;
      x_q   <= q_x_i;
      y_q   <= q_y_i;
    end
  end

  assign dx    = {x_q[COORD_BITS-1], x_q} - {q_x_i[COORD_BITS-1], q_x_i};
  assign dy    = {y_q[COORD_BITS-1], y_q} - {q_y_i[COORD_BITS-1], q_y_i};
  assign mag_x = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
  assign mag_y = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
  assign sqx_d = {{(DIST_W-COORD_BITS-1){1'b0}}, mag_x}
               * {{(DIST_W-COORD_BITS-1){1'b0}}, mag_x};
  assign sqy_d = {{(DIST_W-COORD_BITS-1){1'b0}}, mag_y}
               * {{(DIST_W-COORD_BITS-1){1'b0}}, mag_y};

  always_ff @(posedge clk_i) begin
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
    dist_q <= sqx_q + sqy_q;
  end

  assign better   = !tok_i.any || (dist_q < best_dist_i)
                  || ((dist_q == best_dist_i) && (sub_q < best_sub_i));
  assign take     = valid_q && better;
  assign hit_here = valid_q && (sub_q == q_sub_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q.vld <= tok_i.vld;
      if (tok_i.vld) begin
        tok_q.any <= tok_i.any | valid_q;
        tok_q.hit <= tok_i.hit | hit_here;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.vld) begin
      if (take) begin
        best_dist_q <= dist_q;
        best_sub_q  <= sub_q;
        best_x_q    <= x_q;
        best_y_q    <= y_q;
      end else begin
        best_dist_q <= best_dist_i;
        best_sub_q  <= best_sub_i;
        best_x_q    <= best_x_i;
        best_y_q    <= best_y_i;
      end
    end
  end

  assign tok_o       = tok_q;
  assign best_dist_o = best_dist_q;
  assign best_sub_o  = best_sub_q;
  assign best_x_o    = best_x_q;
  assign best_y_o    = best_y_q;

endmodule

// ----- sv/snpl_checker.sv -----
// Port-level checks for the subnet nearest-point linker, and the bind that attaches them.
// Sees only the top level's ports; no package needed.
module snpl_checker #(
  parameter int COORD_BITS = 24
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [COORD_BITS-1:0] from_x_o,
  input logic [COORD_BITS-1:0] to_x_o,
  input logic                  table_full_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(from_x_o) && $stable(to_x_o)
      && $stable(table_full_o))
    else $error("Stalled output beat changed.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input taken again before the search finished.");

  a_out_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Output beat appeared with no search in progress.");

endmodule

bind subnet_nearest_point_linker_top snpl_checker #(
  .COORD_BITS (COORD_BITS)
) u_snpl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .from_x_o     (from_x_o),
  .to_x_o       (to_x_o),
  .table_full_o (table_full_o)
);

// ----- dv/snpl_link_checker.sv -----
// Checker for the subnet nearest-point linker. It watches both channels and keeps its own
// anchor table to predict each connection, then compares every output beat field by field.
// Standalone; its parameters follow those of the block under test.
module snpl_link_checker #(
  parameter int MAX_SUBNETS = 64,
  parameter int COORD_BITS  = 24,
  parameter int SUBNET_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         start_net_i,
  input  logic [SUBNET_BITS-1:0]       subnet_id_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic signed [COORD_BITS-1:0] from_x_i,
  input  logic signed [COORD_BITS-1:0] from_y_i,
  input  logic signed [COORD_BITS-1:0] to_x_i,
  input  logic signed [COORD_BITS-1:0] to_y_i,
  input  logic                         table_full_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] from_x;
    logic signed [COORD_BITS-1:0] from_y;
    logic signed [COORD_BITS-1:0] to_x;
    logic signed [COORD_BITS-1:0] to_y;
    logic                         table_full;
  } link_t;

  link_t                        links_due [$];
  logic [SUBNET_BITS-1:0]       anchor_net [MAX_SUBNETS];
  logic signed [COORD_BITS-1:0] anchor_x   [MAX_SUBNETS];
  logic signed [COORD_BITS-1:0] anchor_y   [MAX_SUBNETS];
  int                           anchor_fill;
  int                           fails;

  function automatic longint sq_dist(input logic signed [COORD_BITS-1:0] ax,
                                     input logic signed [COORD_BITS-1:0] ay,
                                     input logic signed [COORD_BITS-1:0] bx,
                                     input logic signed [COORD_BITS-1:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    fails++;
  endtask

  task automatic link_segment(input logic                         start,
                              input logic [SUBNET_BITS-1:0]       net,
                              input logic signed [COORD_BITS-1:0] px,
                              input logic signed [COORD_BITS-1:0] py);
    bit     found;
    int     best;
    longint best_d;
    longint d;
    link_t  lk;
    found  = 1'b0;
    best   = 0;
    best_d = 0;
    if (start) begin
      anchor_fill = 0;
    end
    for (int i = 0; i < anchor_fill; i++) begin
      if (anchor_net[i] == net) begin
        return;
      end
    end
    for (int i = 0; i < anchor_fill; i++) begin
      d = sq_dist(anchor_x[i], anchor_y[i], px, py);
      if (!found || d < best_d || (d == best_d && anchor_net[i] < anchor_net[best])) begin
        found  = 1'b1;
        best   = i;
        best_d = d;
      end
    end
    if (found) begin
      lk.from_x     = anchor_x[best];
      lk.from_y     = anchor_y[best];
      lk.to_x       = px;
      lk.to_y       = py;
      lk.table_full = (anchor_fill >= MAX_SUBNETS);
      links_due.push_back(lk);
    end
    if (anchor_fill < MAX_SUBNETS) begin
      anchor_net[anchor_fill] = net;
      anchor_x[anchor_fill]   = px;
      anchor_y[anchor_fill]   = py;
      anchor_fill++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    link_t lk;
    if (!rst_ni) begin
      links_due.delete();
      anchor_fill = 0;
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (links_due.size() == 0) begin
          report_mismatch($sformatf("output beat with no connection due: from (%0d,%0d) to (%0d,%0d)",
                                    from_x_i, from_y_i, to_x_i, to_y_i));
        end else begin
          lk = links_due.pop_front();
          if (from_x_i !== lk.from_x) begin
            report_mismatch($sformatf("from_x got %0d, expected %0d", from_x_i, lk.from_x));
          end
          if (from_y_i !== lk.from_y) begin
            report_mismatch($sformatf("from_y got %0d, expected %0d", from_y_i, lk.from_y));
          end
          if (to_x_i !== lk.to_x) begin
            report_mismatch($sformatf("to_x got %0d, expected %0d", to_x_i, lk.to_x));
          end
          if (to_y_i !== lk.to_y) begin
            report_mismatch($sformatf("to_y got %0d, expected %0d", to_y_i, lk.to_y));
          end
          if (table_full_i !== lk.table_full) begin
            report_mismatch($sformatf("table_full got %0b, expected %0b",
                                      table_full_i, lk.table_full));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        link_segment(start_net_i, subnet_id_i, point_x_i, point_y_i);
      end
      pending_o <= links_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ----- dv/tb_subnet_nearest_point_linker_top.sv -----
// Testbench top for the subnet nearest-point linker: drives directed and random nets of
// segments with varying back-pressure and gives the verdict.
// Depends on subnet_nearest_point_linker_top and snpl_link_checker.
module tb_subnet_nearest_point_linker_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SUBNETS  = 64;
  localparam int COORD_BITS   = 24;
  localparam int SUBNET_BITS  = 16;
  localparam int ITEMS        = 1800;
  localparam int HOLD_CYCLES  = 800;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = MAX_SUBNETS + 20;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic                         start_net_i = 1'b0;
  logic [SUBNET_BITS-1:0]       subnet_id_i = '0;
  logic signed [COORD_BITS-1:0] point_x_i   = '0;
  logic signed [COORD_BITS-1:0] point_y_i   = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [COORD_BITS-1:0] from_x_o;
  logic signed [COORD_BITS-1:0] from_y_o;
  logic signed [COORD_BITS-1:0] to_x_o;
  logic signed [COORD_BITS-1:0] to_y_o;
  logic                         table_full_o;

  int fail_count;
  int links_pending;
  int traffic_phase = 0;
  int segments_sent = 0;
  int quiet_cycles  = 0;
  int hold_count    = 0;
  bit hold_done     = 1'b0;

  subnet_nearest_point_linker_top #(
    .MAX_SUBNETS(MAX_SUBNETS),
    .COORD_BITS (COORD_BITS),
    .SUBNET_BITS(SUBNET_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_net_i (start_net_i),
    .subnet_id_i (subnet_id_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .from_x_o    (from_x_o),
    .from_y_o    (from_y_o),
    .to_x_o      (to_x_o),
    .to_y_o      (to_y_o),
    .table_full_o(table_full_o)
  );

  snpl_link_checker #(
    .MAX_SUBNETS(MAX_SUBNETS),
    .COORD_BITS (COORD_BITS),
    .SUBNET_BITS(SUBNET_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .start_net_i (start_net_i),
    .subnet_id_i (subnet_id_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .from_x_i    (from_x_o),
    .from_y_i    (from_y_o),
    .to_x_i      (to_x_o),
    .to_y_i      (to_y_o),
    .table_full_i(table_full_o),
    .fail_count_o(fail_count),
    .pending_o   (links_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver holds off once for a long stretch when the no-idle phase begins.
  always @(posedge clk_i) begin
    int rx_idle_pct;
    rx_idle_pct = (traffic_phase == 0) ? 66 : (traffic_phase == 1) ? 13 : 0;
    if (traffic_phase == 2 && !hold_done) begin
      if (hold_count < HOLD_CYCLES) begin
        hold_count++;
        out_stall_i <= 1'b1;
      end else begin
        hold_done = 1'b1;
        out_stall_i <= 1'b0;
      end
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic drive_segment(input logic                         start,
                               input logic [SUBNET_BITS-1:0]       net,
                               input logic signed [COORD_BITS-1:0] px,
                               input logic signed [COORD_BITS-1:0] py);
    int tx_idle_pct;
    tx_idle_pct = (traffic_phase == 0) ? 13 : (traffic_phase == 1) ? 66 : 0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    start_net_i <= start;
    subnet_id_i <= net;
    point_x_i   <= px;
    point_y_i   <= py;
    do @(posedge clk_i); while (in_stall_o);
    segments_sent++;
  endtask

  function automatic logic signed [COORD_BITS-1:0] pick_coord(
      input int mode, input logic signed [COORD_BITS-1:0] center);
    case (mode)
      0:       return COORD_BITS'($urandom);
      1:       return COORD_BITS'($urandom_range(8) - 4);
      default: return center + COORD_BITS'($urandom_range(8190) - 4095);
    endcase
  endfunction

  // Each net's first subnet beat carries the start flag; beats mix new subnets, repeats of known ones and noise.
  task automatic run_nets();
    logic [SUBNET_BITS-1:0]       members [$];
    logic [SUBNET_BITS-1:0]       net;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    int                           net_size;
    int                           mode;
    bit                           first_net;
    first_net = 1'b1;
    while (segments_sent < ITEMS) begin
      traffic_phase = (segments_sent * 3 / ITEMS > 2) ? 2 : segments_sent * 3 / ITEMS;
      if (first_net || $urandom_range(99) < 12) begin
        net_size = $urandom_range(MAX_SUBNETS + 8, MAX_SUBNETS - 4);
      end else begin
        net_size = $urandom_range(12, 2);
      end
      mode      = first_net ? 1 : $urandom_range(2);
      first_net = 1'b0;
      center_x  = COORD_BITS'($urandom);
      center_y  = COORD_BITS'($urandom);
      members.delete();
      for (int n = 0; n < net_size; n++) begin
        if (n > 0 && $urandom_range(99) < 30) begin
          drive_segment(1'b0, members[$urandom_range(members.size() - 1)],
                        pick_coord(mode, center_x), pick_coord(mode, center_y));
        end
        if ($urandom_range(99) < 6) begin
          drive_segment($urandom_range(15) == 0, SUBNET_BITS'($urandom),
                        COORD_BITS'($urandom), COORD_BITS'($urandom));
        end
        net = ($urandom_range(3) == 0) ? SUBNET_BITS'($urandom_range(63))
                                       : SUBNET_BITS'($urandom);
        drive_segment(n == 0, net, pick_coord(mode, center_x), pick_coord(mode, center_y));
        members.push_back(net);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_segment(1'b1, 16'h0000, 24'h7FFFFF, 24'h7FFFFF);
    drive_segment(1'b0, 16'hFFFF, 24'h800000, 24'h800000);
    drive_segment(1'b0, 16'h1234, 24'h000000, 24'h000000);
    drive_segment(1'b0, 16'hFFFF, 24'h000001, 24'h000001);
    drive_segment(1'b0, 16'h0000, 24'h000007, 24'h000007);
    drive_segment(1'b0, 16'h0001, 24'h800000, 24'h7FFFFF);
    drive_segment(1'b0, 16'hFFFE, 24'h7FFFFF, 24'h800000);
    drive_segment(1'b1, 16'h0100, 24'sd10, 24'sd0);
    drive_segment(1'b0, 16'h0050, -24'sd10, 24'sd0);
    drive_segment(1'b0, 16'h0200, 24'sd0, 24'sd0);
    drive_segment(1'b0, 16'h0300, 24'sd0, 24'sd5);
    drive_segment(1'b0, 16'h0400, 24'sd0, -24'sd5);
    drive_segment(1'b0, 16'h0020, 24'sd5, 24'sd0);
    drive_segment(1'b1, 16'h0200, 24'sd5, 24'sd5);
    drive_segment(1'b0, 16'h0100, 24'sd5, 24'sd5);
    drive_segment(1'b0, 16'hAAAA, 24'h555555, 24'hAAAAAA);
    drive_segment(1'b0, 16'h5555, 24'hAAAAAA, 24'h555555);

    run_nets();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (links_pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/snpl_pkg.sv
sv/snpl_cell.sv
sv/subnet_nearest_point_linker_top.sv
sv/snpl_checker.sv
dv/snpl_link_checker.sv
dv/tb_subnet_nearest_point_linker_top.sv
